// ===== rtl/alpha_weighted_box_resampler_assert.svh =====
// Assertion macros used by the resampler sequencer (awbr_ctrl).
`ifndef ALPHA_WEIGHTED_BOX_RESAMPLER_ASSERT_SVH
`define ALPHA_WEIGHTED_BOX_RESAMPLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AWBR_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("awbr check failed");

// Next-cycle implication, checked outside reset.
`define AWBR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("awbr check failed");

`endif

// ===== rtl/awbr_pkg.sv =====
`default_nettype none

package awbr_pkg;

   // request codes
   localparam logic REQ_STORE   = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_DST_HEIGHT = 2'd3;

   localparam int SRC_W   = 9;   // source size register width
   localparam int DST_W   = 13;  // destination size register width
   localparam int CSR_W   = 13;  // config write data width
   localparam int PROD_W  = DST_W + SRC_W;  // bound numerator
   localparam int CNT_W   = 2 * SRC_W;      // texel count of a box
   localparam int ASUM_W  = CNT_W + 8;      // alpha / plain color sum
   localparam int WSUM_W  = CNT_W + 16;     // alpha weighted color sum
   localparam int NUM_W   = WSUM_W + 1;     // divider numerator
   localparam int DEN_W   = ASUM_W;         // divider denominator

   // divider jobs in issue order
   typedef enum logic [2:0] {
      OP_R0, OP_R1, OP_C0, OP_C1, OP_RED, OP_GREEN, OP_BLUE, OP_ALPHA
   } op_type;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  texel_x;
      logic [7:0]  texel_y;
      logic [7:0]  in_red;
      logic [7:0]  in_green;
      logic [7:0]  in_blue;
      logic [7:0]  in_alpha;
      logic [11:0] dst_row;
      logic [11:0] dst_col;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_item_type;

   typedef struct packed {
      logic   capture;
      logic   store_wr;
      logic   div_start;
      op_type div_op;
      logic   walk_init;
      logic   walk_step;
      logic   rsp_fire;
   } cmd_type;

   typedef struct packed {
      logic is_store;
      logic compute_ok;
      logic div_done;
      logic walk_last;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/awbr_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module awbr_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [awbr_pkg::NUM_W-1:0]   numer,
   input  wire logic [awbr_pkg::DEN_W-1:0]   denom,
   output logic                              done,
   output logic [awbr_pkg::NUM_W-1:0]        quot
);

   localparam int NW = awbr_pkg::NUM_W;
   localparam int DW = awbr_pkg::DEN_W;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          run_ff;
   logic          done_ff;
   logic [DW:0]   trial;
   logic          qbit;

   // one shift-subtract step
   always_comb begin
      trial  = {rem_ff, num_ff[NW-1]};
      qbit   = (trial >= {1'b0, den_ff});
      rem_in = qbit ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
      num_in = {num_ff[NW-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CW'(NW);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands and partial results
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numer;
         den_ff <= denom;
         rem_ff <= '0;
      end else if (run_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

`default_nettype wire

// ===== rtl/awbr_datapath.sv =====
`default_nettype none

// Texel store, box walker, accumulators and result registers.
module awbr_datapath #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_DST_DIM    = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire awbr_pkg::req_item_type      req_data,
   input  wire logic                        csr_wr,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [awbr_pkg::CSR_W-1:0]  csr_wdata,
   input  wire awbr_pkg::cmd_type           cmd,
   output awbr_pkg::status_type             status,
   output logic                             rsp_valid,
   output awbr_pkg::rsp_item_type           rsp_data
);

   localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW     = awbr_pkg::SRC_W;
   localparam int DW     = awbr_pkg::DST_W;
   localparam int PW     = awbr_pkg::PROD_W;
   localparam int NW     = awbr_pkg::NUM_W;
   localparam int QW     = awbr_pkg::DEN_W;

   logic [31:0] mem [DEPTH];

   logic [SW-1:0] src_w_ff, src_h_ff;
   logic [DW-1:0] dst_w_ff, dst_h_ff;
   awbr_pkg::req_item_type req_ff;

   logic [SW-1:0] r0_ff, r1_ff, c0_ff, c1_ff;
   logic [SW-1:0] x_ff, y_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [31:0]   rd_data_ff;
   logic          rd_vld_ff;

   logic [awbr_pkg::WSUM_W-1:0] wr_ff, wg_ff, wb_ff;
   logic [awbr_pkg::ASUM_W-1:0] pr_ff, pg_ff, pb_ff, asum_ff;
   logic [awbr_pkg::CNT_W-1:0]  n_ff;

   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic       rsp_valid_ff;

   logic              store_ok;
   logic              sizes_ok;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [DW-1:0]     mul_a;
   logic [SW-1:0]     mul_b;
   logic [PW-1:0]     prod;
   logic [NW-1:0]     numer;
   logic [QW-1:0]     denom;
   logic              asum_zero;
   logic              div_done;
   logic [NW-1:0]     quot;
   logic [SW-1:0]     qb;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SW'(1);
         src_h_ff <= SW'(1);
         dst_w_ff <= DW'(1);
         dst_h_ff <= DW'(1);
      end else if (csr_wr) begin
         unique case (csr_index)
            awbr_pkg::CSR_SRC_WIDTH:  src_w_ff <= csr_wdata[SW-1:0];
            awbr_pkg::CSR_SRC_HEIGHT: src_h_ff <= csr_wdata[SW-1:0];
            awbr_pkg::CSR_DST_WIDTH:  dst_w_ff <= csr_wdata[DW-1:0];
            awbr_pkg::CSR_DST_HEIGHT: dst_h_ff <= csr_wdata[DW-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // request checks
   always_comb begin
      store_ok = ({1'b0, req_ff.texel_x} < SW'(src_w_ff)) &&
                 ({1'b0, req_ff.texel_y} < SW'(src_h_ff)) &&
                 (32'(req_ff.texel_x) < 32'(MAX_SRC_WIDTH)) &&
                 (32'(req_ff.texel_y) < 32'(MAX_SRC_HEIGHT));
      sizes_ok = (src_w_ff != '0) && (src_h_ff != '0) &&
                 (dst_w_ff != '0) && (dst_h_ff != '0) &&
                 (32'(src_w_ff) <= 32'(MAX_SRC_WIDTH)) &&
                 (32'(src_h_ff) <= 32'(MAX_SRC_HEIGHT)) &&
                 (32'(dst_w_ff) <= 32'(MAX_DST_DIM)) &&
                 (32'(dst_h_ff) <= 32'(MAX_DST_DIM));
      status.is_store   = (req_ff.req_type == awbr_pkg::REQ_STORE);
      status.compute_ok = sizes_ok &&
                          (DW'(req_ff.dst_row) < dst_h_ff) &&
                          (DW'(req_ff.dst_col) < dst_w_ff);
      status.div_done   = div_done;
      status.walk_last  = (x_ff == c1_ff - 1'b1) && (y_ff == r1_ff - 1'b1);
   end

   assign wr_addr = ADDR_W'(ADDR_W'(req_ff.texel_y) * ADDR_W'(MAX_SRC_WIDTH)) +
                    ADDR_W'(req_ff.texel_x);
   assign rd_addr = base_ff + ADDR_W'(x_ff);

   // texel store
   always_ff @(posedge clock) begin
      if (cmd.store_wr && store_ok) begin
         mem[wr_addr] <= {req_ff.in_alpha, req_ff.in_blue,
                          req_ff.in_green, req_ff.in_red};
      end
      if (cmd.walk_step) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.walk_step;
      end
   end

   // box walker, row by row
   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         x_ff    <= c0_ff;
         y_ff    <= r0_ff;
         base_ff <= ADDR_W'(ADDR_W'(r0_ff) * ADDR_W'(MAX_SRC_WIDTH));
      end else if (cmd.walk_step) begin
         if (x_ff == c1_ff - 1'b1) begin
            x_ff    <= c0_ff;
            y_ff    <= y_ff + 1'b1;
            base_ff <= base_ff + ADDR_W'(MAX_SRC_WIDTH);
         end else begin
            x_ff <= x_ff + 1'b1;
         end
      end
   end

   // accumulators
   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         wr_ff <= '0; wg_ff <= '0; wb_ff <= '0;
         pr_ff <= '0; pg_ff <= '0; pb_ff <= '0;
         asum_ff <= '0;
         n_ff <= '0;
      end else if (rd_vld_ff) begin
         wr_ff   <= wr_ff + awbr_pkg::WSUM_W'(rd_data_ff[7:0] * rd_data_ff[31:24]);
         wg_ff   <= wg_ff + awbr_pkg::WSUM_W'(rd_data_ff[15:8] * rd_data_ff[31:24]);
         wb_ff   <= wb_ff + awbr_pkg::WSUM_W'(rd_data_ff[23:16] * rd_data_ff[31:24]);
         pr_ff   <= pr_ff + awbr_pkg::ASUM_W'(rd_data_ff[7:0]);
         pg_ff   <= pg_ff + awbr_pkg::ASUM_W'(rd_data_ff[15:8]);
         pb_ff   <= pb_ff + awbr_pkg::ASUM_W'(rd_data_ff[23:16]);
         asum_ff <= asum_ff + awbr_pkg::ASUM_W'(rd_data_ff[31:24]);
         n_ff    <= n_ff + 1'b1;
      end
   end

   // divider operand select
   assign asum_zero = (asum_ff == '0);
   assign prod      = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      numer = '0;
      denom = QW'(1);
      unique case (cmd.div_op)
         awbr_pkg::OP_R0: begin
            mul_a = DW'(req_ff.dst_row);
            mul_b = src_h_ff;
            numer = NW'(prod);
            denom = QW'(dst_h_ff);
         end
         awbr_pkg::OP_R1: begin
            mul_a = DW'(req_ff.dst_row) + 1'b1;
            mul_b = src_h_ff;
            numer = NW'(prod);
            denom = QW'(dst_h_ff);
         end
         awbr_pkg::OP_C0: begin
            mul_a = DW'(req_ff.dst_col);
            mul_b = src_w_ff;
            numer = NW'(prod);
            denom = QW'(dst_w_ff);
         end
         awbr_pkg::OP_C1: begin
            mul_a = DW'(req_ff.dst_col) + 1'b1;
            mul_b = src_w_ff;
            numer = NW'(prod);
            denom = QW'(dst_w_ff);
         end
         awbr_pkg::OP_RED: begin
            numer = asum_zero ? NW'(pr_ff) + NW'(n_ff >> 1)
                              : NW'(wr_ff) + NW'(asum_ff >> 1);
            denom = asum_zero ? QW'(n_ff) : asum_ff;
         end
         awbr_pkg::OP_GREEN: begin
            numer = asum_zero ? NW'(pg_ff) + NW'(n_ff >> 1)
                              : NW'(wg_ff) + NW'(asum_ff >> 1);
            denom = asum_zero ? QW'(n_ff) : asum_ff;
         end
         awbr_pkg::OP_BLUE: begin
            numer = asum_zero ? NW'(pb_ff) + NW'(n_ff >> 1)
                              : NW'(wb_ff) + NW'(asum_ff >> 1);
            denom = asum_zero ? QW'(n_ff) : asum_ff;
         end
         awbr_pkg::OP_ALPHA: begin
            numer = NW'(asum_ff) + NW'(n_ff >> 1);
            denom = QW'(n_ff);
         end
         default: ;
      endcase
   end

   awbr_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (numer),
      .denom (denom),
      .done  (div_done),
      .quot  (quot)
   );

   // quotient write back; an empty span widens to one texel
   assign qb = quot[SW-1:0];

   always_ff @(posedge clock) begin
      if (div_done) begin
         unique case (cmd.div_op)
            awbr_pkg::OP_R0:    r0_ff    <= qb;
            awbr_pkg::OP_R1:    r1_ff    <= (qb <= r0_ff) ? r0_ff + 1'b1 : qb;
            awbr_pkg::OP_C0:    c0_ff    <= qb;
            awbr_pkg::OP_C1:    c1_ff    <= (qb <= c0_ff) ? c0_ff + 1'b1 : qb;
            awbr_pkg::OP_RED:   red_ff   <= quot[7:0];
            awbr_pkg::OP_GREEN: green_ff <= quot[7:0];
            awbr_pkg::OP_BLUE:  blue_ff  <= quot[7:0];
            awbr_pkg::OP_ALPHA: alpha_ff <= quot[7:0];
            default: ;
         endcase
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_fire;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.out_red   = red_ff;
   assign rsp_data.out_green = green_ff;
   assign rsp_data.out_blue  = blue_ff;
   assign rsp_data.out_alpha = alpha_ff;

endmodule

`default_nettype wire

// ===== rtl/awbr_ctrl.sv =====
`default_nettype none

`include "alpha_weighted_box_resampler_assert.svh"

// Request sequencer: texel store, or bounds, box walk, color divides, result.
module awbr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire awbr_pkg::status_type  status,
   output logic                       busy,
   output awbr_pkg::cmd_type          cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_DIV_GO, ST_DIV_WAIT, ST_WALK_INIT, ST_WALK,
      ST_DRAIN, ST_RESP
   } state_type;

   state_type        state_ff;
   awbr_pkg::op_type op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= awbr_pkg::OP_R0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               if (!status.is_store && status.compute_ok) begin
                  op_ff    <= awbr_pkg::OP_R0;
                  state_ff <= ST_DIV_GO;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (status.div_done) begin
                  priority if (op_ff == awbr_pkg::OP_C1) begin
                     state_ff <= ST_WALK_INIT;
                  end else if (op_ff == awbr_pkg::OP_ALPHA) begin
                     state_ff <= ST_RESP;
                  end else begin
                     op_ff    <= awbr_pkg::op_type'(op_ff + 1'b1);
                     state_ff <= ST_DIV_GO;
                  end
               end
            end
            ST_WALK_INIT: begin
               state_ff <= ST_WALK;
            end
            ST_WALK: begin
               if (status.walk_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               op_ff    <= awbr_pkg::OP_RED;
               state_ff <= ST_DIV_GO;
            end
            ST_RESP: begin
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // commands decoded from state
   always_comb begin
      cmd           = '0;
      cmd.capture   = start && (state_ff == ST_IDLE);
      cmd.store_wr  = (state_ff == ST_DECODE) && status.is_store;
      cmd.div_start = (state_ff == ST_DIV_GO);
      cmd.div_op    = op_ff;
      cmd.walk_init = (state_ff == ST_WALK_INIT);
      cmd.walk_step = (state_ff == ST_WALK);
      cmd.rsp_fire  = (state_ff == ST_RESP);
   end

   assign busy = (state_ff != ST_IDLE);

   `AWBR_ASSERT_NEXT(a_one_result, clock, reset, cmd.rsp_fire, !cmd.rsp_fire)
   `AWBR_ASSERT_NOW(a_done_waited, clock, reset, status.div_done,
                    state_ff == ST_DIV_WAIT)
   `AWBR_ASSERT_NEXT(a_capture_decode, clock, reset, cmd.capture,
                     state_ff == ST_DECODE)

endmodule

`default_nettype wire

// ===== rtl/alpha_weighted_box_resampler.sv =====
// Alpha-weighted box resampler for RGBA8. Store requests (req_type 0) write
// one texel; a compute request (req_type 1) returns one pixel on rsp_data,
// marked by a one-cycle rsp_valid strobe that cannot be held off. A compute
// keeps busy high until its result is ready, and its strobe is registered
// from the last busy state, so it rises as busy falls: the single shared
// restoring divider (35 steps per quotient) runs four box bounds and four
// rounded means, and the box is read from the texel store one texel per
// cycle. Requests outside the configured sizes produce nothing. The texel
// store has no reset; only texels written since power-up may be covered by
// a compute. Configure only while busy is low; csr_ready is always high.
`default_nettype none

module alpha_weighted_box_resampler #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_DST_DIM    = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire awbr_pkg::req_item_type      req_data,
   output logic                             rsp_valid,
   output awbr_pkg::rsp_item_type           rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [awbr_pkg::CSR_W-1:0]  csr_wdata
);

   awbr_pkg::cmd_type    cmd;
   awbr_pkg::status_type status;

   assign csr_ready = 1'b1;

   awbr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   awbr_datapath #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .MAX_DST_DIM    (MAX_DST_DIM)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
